### rtl/plm_mm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plm_mm_pkg
// Shared widths, reset values and register codes for the minmod face
// reconstruction core.
// ----------------------------------------------------------------------------
package plm_mm_pkg;

  localparam int FIELD_W          = 32;
  localparam int THETA_W          = 18;
  localparam int FLOOR_W          = 31;
  localparam int SAMPLE_WIDTH_DEF = 32;
  localparam int CFG_ADDR_W       = 3;
  localparam int CFG_DATA_W       = 32;
  localparam int IN_USER_W        = 3;
  localparam int OUT_DATA_W       = 3 * FIELD_W;

  localparam logic [THETA_W-1:0] THETA_RST = 18'd98304;
  localparam logic [FLOOR_W-1:0] FLOOR_RST = 31'd1;

  // rounding of half a slope from scale 2^-32 down to q16.16
  localparam int ROUND_HALF = 65536;
  localparam int HALF_SHIFT = 17;
  // central difference halved, at scale 2^-32
  localparam int MID_SHIFT  = 15;

  typedef enum logic {
    REG_THETA = 1'b0,
    REG_FLOOR = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic flux_nonneg;
    logic apply_floor;
  } face_ctl_t;

endpackage

### rtl/plm_minmod_face_reconstruct_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plm_minmod_face_reconstruct_core
// Streams a row of cell values and returns left, right and upwind face values
// at each interface, using a generalized minmod limited linear slope.
// ----------------------------------------------------------------------------
//  channel  | direction | contents
//  in_      | slave     | tdata: sample; tuser: row_start, flux_nonneg, apply_floor
//  out_     | master    | tdata: left_face, right_face, upwind_face
//  cfg_     | apb slave | theta at 0x0, floor_value at 0x4
//
//  one item per cycle while the output is not held; each taken item passes the
//  pipeline stages in order: differences, theta multiply, limiter, face and saturate
//  items that fill the window give no result and leave the pipeline at once
//  out_tready low holds the output; stages fill up before in_tready drops
//  rst_n is synchronous; it empties the window and restores both registers
// ----------------------------------------------------------------------------
module plm_minmod_face_reconstruct_core
  import plm_mm_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [FIELD_W-1:0]    in_tdata,   // sample
  input  logic [IN_USER_W-1:0]  in_tuser,   // row_start, flux_nonneg, apply_floor
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // left_face, right_face, upwind_face
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  localparam int EW  = (SAMPLE_WIDTH > FIELD_W) ? FIELD_W + 1 : SAMPLE_WIDTH;
  localparam int DW  = EW + 1;
  localparam int PW  = DW + THETA_W + 1;
  localparam int MW  = PW - 1;
  localparam int HM  = MW - HALF_SHIFT;
  localparam int HW  = HM + 1;
  localparam int LW0 = ((EW > HW) ? EW : HW) + 1;
  localparam int LW  = (LW0 < FIELD_W + 1) ? FIELD_W + 1 : LW0;
  localparam int CW  = (SAMPLE_WIDTH + 1 > LW) ? SAMPLE_WIDTH + 1 : LW;

  localparam logic signed [CW-1:0] SAT_HI =
    {{(CW - SAMPLE_WIDTH + 1){1'b0}}, {(SAMPLE_WIDTH - 1){1'b1}}};
  localparam logic signed [CW-1:0] SAT_LO = ~SAT_HI;

  // configuration
  logic [THETA_W-1:0] theta_r;
  logic [FLOOR_W-1:0] floor_r;
  cfg_reg_t           cfg_sel;
  logic               cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_sel    = cfg_reg_t'(cfg_paddr[2]);
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      theta_r <= THETA_RST;
      floor_r <= FLOOR_RST;
    end else if (cfg_wr) begin
      case (cfg_sel)
        REG_THETA: theta_r <= cfg_pwdata[THETA_W-1:0];
        REG_FLOOR: floor_r <= cfg_pwdata[FLOOR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_THETA: cfg_prdata = CFG_DATA_W'(theta_r);
      REG_FLOOR: cfg_prdata = CFG_DATA_W'(floor_r);
      default:   cfg_prdata = '0;
    endcase
  end

  // input sample view
  logic signed [EW-1:0] d_in;

  generate
    if (SAMPLE_WIDTH > FIELD_W) begin : g_wide
      assign d_in = {1'b0, in_tdata};
    end else begin : g_narrow
      assign d_in = in_tdata[EW-1:0];
    end
  endgenerate

  // handshake chain
  logic s1_v_r, s2_v_r, s3_v_r, out_v_r;
  logic out_rdy, s3_rdy, s2_rdy, s1_rdy;
  logic in_acc;

  assign out_rdy   = !out_v_r || out_tready;
  assign s3_rdy    = !s3_v_r || out_rdy;
  assign s2_rdy    = !s2_v_r || s3_rdy;
  assign s1_rdy    = !s1_v_r || s2_rdy;
  assign in_tready = s1_rdy;
  assign in_acc    = in_tvalid && in_tready;

  // window
  logic signed [EW-1:0] win_r [3];
  logic [1:0]           fill_r;
  logic [1:0]           fill_eff;
  logic [1:0]           fill_nxt;
  logic                 produce;
  face_ctl_t            ctl_in;

  assign fill_eff = in_tuser[0] ? 2'd0 : fill_r;
  assign produce  = (fill_eff == 2'd3);
  assign fill_nxt = produce ? 2'd3 : fill_eff + 2'd1;
  assign ctl_in   = '{flux_nonneg: in_tuser[1], apply_floor: in_tuser[2]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= 2'd0;
    end else if (in_acc) begin
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      win_r[0] <= win_r[1];
      win_r[1] <= win_r[2];
      win_r[2] <= d_in;
    end
  end

  // stage 1: differences
  logic signed [DW-1:0] dab_nxt, dbc_nxt, dcd_nxt, dac_nxt, dbd_nxt;
  logic signed [DW-1:0] s1_dab_r, s1_dbc_r, s1_dcd_r, s1_dac_r, s1_dbd_r;
  logic signed [EW-1:0] s1_b_r, s1_c_r;
  face_ctl_t            s1_ctl_r;

  assign dab_nxt = DW'(win_r[1]) - DW'(win_r[0]);
  assign dbc_nxt = DW'(win_r[2]) - DW'(win_r[1]);
  assign dcd_nxt = DW'(d_in) - DW'(win_r[2]);
  assign dac_nxt = DW'(win_r[2]) - DW'(win_r[0]);
  assign dbd_nxt = DW'(d_in) - DW'(win_r[1]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_rdy) begin
      s1_v_r <= in_acc && produce;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && s1_rdy) begin
      s1_dab_r <= dab_nxt;
      s1_dbc_r <= dbc_nxt;
      s1_dcd_r <= dcd_nxt;
      s1_dac_r <= dac_nxt;
      s1_dbd_r <= dbd_nxt;
      s1_b_r   <= win_r[1];
      s1_c_r   <= win_r[2];
      s1_ctl_r <= ctl_in;
    end
  end

  // stage 2: theta products
  logic signed [THETA_W:0] theta_s;
  logic signed [PW-1:0]    pab_nxt, pbc_nxt, pcd_nxt;
  logic signed [PW-1:0]    s2_pab_r, s2_pbc_r, s2_pcd_r;
  logic signed [DW-1:0]    s2_dac_r, s2_dbd_r;
  logic signed [EW-1:0]    s2_b_r, s2_c_r;
  face_ctl_t               s2_ctl_r;

  assign theta_s = {1'b0, theta_r};
  assign pab_nxt = s1_dab_r * theta_s;
  assign pbc_nxt = s1_dbc_r * theta_s;
  assign pcd_nxt = s1_dcd_r * theta_s;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_rdy) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_rdy && s1_v_r) begin
      s2_pab_r <= pab_nxt;
      s2_pbc_r <= pbc_nxt;
      s2_pcd_r <= pcd_nxt;
      s2_dac_r <= s1_dac_r;
      s2_dbd_r <= s1_dbd_r;
      s2_b_r   <= s1_b_r;
      s2_c_r   <= s1_c_r;
      s2_ctl_r <= s1_ctl_r;
    end
  end

  // stage 3: limiter and half slope
  function automatic logic signed [HW-1:0] half_minmod(
    input logic signed [PW-1:0] dl,
    input logic signed [PW-1:0] dr,
    input logic signed [DW-1:0] dc
  );
    logic signed [PW-1:0] dm;
    logic                 neg;
    logic                 agree;
    logic [PW-1:0]        al, ar, am;
    logic [MW-1:0]        mag;
    logic [MW-1:0]        rsum;
    logic [HM-1:0]        hm;
    dm    = {{(PW - DW){dc[DW-1]}}, dc} <<< MID_SHIFT;
    neg   = dl[PW-1];
    agree = (dl != '0) && (dr != '0) && (dm != '0) &&
            (dr[PW-1] == neg) && (dm[PW-1] == neg);
    al    = dl[PW-1] ? -dl : dl;
    ar    = dr[PW-1] ? -dr : dr;
    am    = dm[PW-1] ? -dm : dm;
    mag   = al[MW-1:0];
    if (ar[MW-1:0] < mag) begin
      mag = ar[MW-1:0];
    end
    if (am[MW-1:0] < mag) begin
      mag = am[MW-1:0];
    end
    rsum = mag + MW'(ROUND_HALF);
    hm   = rsum[MW-1:HALF_SHIFT];
    if (!agree) begin
      return '0;
    end else if (neg) begin
      return -$signed({1'b0, hm});
    end else begin
      return $signed({1'b0, hm});
    end
  endfunction

  logic signed [HW-1:0] s3_hl_r, s3_hr_r;
  logic signed [EW-1:0] s3_b_r, s3_c_r;
  face_ctl_t            s3_ctl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (s3_rdy) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_rdy && s2_v_r) begin
      s3_hl_r  <= half_minmod(s2_pab_r, s2_pbc_r, s2_dac_r);
      s3_hr_r  <= half_minmod(s2_pbc_r, s2_pcd_r, s2_dbd_r);
      s3_b_r   <= s2_b_r;
      s3_c_r   <= s2_c_r;
      s3_ctl_r <= s2_ctl_r;
    end
  end

  // stage 4: faces, floor, saturation
  function automatic logic [FIELD_W-1:0] sat_face(input logic signed [LW-1:0] x);
    logic signed [CW-1:0] xe;
    logic signed [CW-1:0] xs;
    xe = CW'(x);
    if (xe > SAT_HI) begin
      xs = SAT_HI;
    end else if (xe < SAT_LO) begin
      xs = SAT_LO;
    end else begin
      xs = xe;
    end
    return xs[FIELD_W-1:0];
  endfunction

  logic signed [LW-1:0]     lf, rf, uf, fl, lf_fl, rf_fl;
  logic [OUT_DATA_W-1:0]    out_nxt;
  logic [OUT_DATA_W-1:0]    out_tdata_r;

  always_comb begin
    lf    = LW'(s3_b_r) + LW'(s3_hl_r);
    rf    = LW'(s3_c_r) - LW'(s3_hr_r);
    uf    = s3_ctl_r.flux_nonneg ? lf : rf;
    fl    = LW'(floor_r);
    lf_fl = (s3_ctl_r.apply_floor && (lf < fl)) ? fl : lf;
    rf_fl = (s3_ctl_r.apply_floor && (rf < fl)) ? fl : rf;
    out_nxt = {sat_face(uf), sat_face(rf_fl), sat_face(lf_fl)};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_rdy) begin
      out_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_rdy && s3_v_r) begin
      out_tdata_r <= out_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_tdata_r;

endmodule

### sim/plm_minmod_face_reconstruct_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the minmod face reconstruction core. Rows of cell
// samples go in through a queue-fed driver, and an in-bench predictor works out
// the left, right and upwind faces for every item that fills an interface. A
// monitor compares each result with the oldest expected face set. Both sides
// idle at random, and the limiter and floor registers go through several
// settings between phases, the extremes among them.
// ----------------------------------------------------------------------------
module testbench
  import plm_mm_pkg::*;
();

  localparam int     SETTLE_CYCLES = 8;
  localparam int     CYCLE_LIMIT   = 150000;
  localparam int     RANDOM_ITEMS  = 85;
  localparam longint SAT_HI        = 64'sd2147483647;
  localparam longint SAT_LO        = -64'sd2147483648;

  typedef struct {
    logic [FIELD_W-1:0] sample;
    logic               row_start;
    logic               flux_nonneg;
    logic               apply_floor;
  } cell_item_t;

  typedef struct {
    logic [FIELD_W-1:0] left_face;
    logic [FIELD_W-1:0] right_face;
    logic [FIELD_W-1:0] upwind_face;
  } face_set_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [FIELD_W-1:0]    in_tdata = '0;   // sample
  logic [IN_USER_W-1:0]  in_tuser = '0;   // row_start, flux_nonneg, apply_floor
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;       // left_face, right_face, upwind_face
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  plm_minmod_face_reconstruct_core i_dut (.*);

  // predictor state and settings
  logic [THETA_W-1:0] theta_q = THETA_RST;
  logic [FLOOR_W-1:0] floor_q = FLOOR_RST;
  longint             window_q [3];
  int                 fill_q = 0;

  cell_item_t pending_cells [$];
  face_set_t  expected_faces [$];
  cell_item_t next_cell;
  face_set_t  got_faces;

  int  cells_queued = 0;
  int  cells_taken = 0;
  int  rows_sent = 0;
  int  faces_checked = 0;
  int  mismatches = 0;
  int  gap_left = 0;
  int  stall_left = 0;
  int  cycle_count = 0;
  logic calm = 1'b0;

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic int sign_of_l(longint x);
    return (x > 0) ? 1 : ((x < 0) ? -1 : 0);
  endfunction

  function automatic longint mag(longint x);
    return (x < 0) ? -x : x;
  endfunction

  // limited slope of cell v at scale 2^-32
  function automatic longint minmod_slope(longint vm, longint v, longint vp);
    longint dl, dr, dm, m;
    int     s;
    dl = (v - vm) * longint'(theta_q);
    dr = (vp - v) * longint'(theta_q);
    dm = (vp - vm) * (64'sd1 <<< MID_SHIFT);
    s  = sign_of_l(dl);
    if (s == 0 || sign_of_l(dr) != s || sign_of_l(dm) != s) return 0;
    m = mag(dl);
    if (mag(dr) < m) m = mag(dr);
    if (mag(dm) < m) m = mag(dm);
    return (s > 0) ? m : -m;
  endfunction

  // half slope in q16.16, ties away from zero
  function automatic longint half_slope_q16(longint dv);
    longint h;
    h = (mag(dv) + longint'(ROUND_HALF)) >>> HALF_SHIFT;
    return (dv < 0) ? -h : h;
  endfunction

  function automatic logic [FIELD_W-1:0] clamp32(longint x);
    if (x > SAT_HI) return 32'h7fff_ffff;
    if (x < SAT_LO) return 32'h8000_0000;
    return x[FIELD_W-1:0];
  endfunction

  task automatic take_cell(cell_item_t c);
    longint    d, lf, rf, up, fl;
    face_set_t f;
    d = longint'(signed'(c.sample));
    if (c.row_start) fill_q = 0;
    if (fill_q >= 3) begin
      lf = window_q[1] + half_slope_q16(minmod_slope(window_q[0], window_q[1], window_q[2]));
      rf = window_q[2] - half_slope_q16(minmod_slope(window_q[1], window_q[2], d));
      up = c.flux_nonneg ? lf : rf;
      fl = longint'(floor_q);
      if (c.apply_floor) begin
        if (lf < fl) lf = fl;
        if (rf < fl) rf = fl;
      end
      f.left_face   = clamp32(lf);
      f.right_face  = clamp32(rf);
      f.upwind_face = clamp32(up);
      expected_faces.push_back(f);
    end
    window_q[0] = window_q[1];
    window_q[1] = window_q[2];
    window_q[2] = d;
    if (fill_q < 3) fill_q++;
  endtask

  task automatic check_field(string name, logic [FIELD_W-1:0] want, logic [FIELD_W-1:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch in %s of face set %0d: expected %h, got %h",
                 name, faces_checked, want, got);
    end
  endtask

  // input driver and predictor feed
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        take_cell(cell_item_t'{in_tdata, in_tuser[0], in_tuser[1], in_tuser[2]});
        cells_taken++;
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
          gap_left = $urandom_range(0, 10);
          in_tvalid <= 1'b0;
        end else if (pending_cells.size() != 0) begin
          next_cell = pending_cells.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= next_cell.sample;
          in_tuser  <= {next_cell.apply_floor, next_cell.flux_nonneg, next_cell.row_start};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_faces.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected face set: got %h", out_tdata);
        end else begin
          got_faces = expected_faces.pop_front();
          check_field("left_face", got_faces.left_face, out_tdata[FIELD_W-1:0]);
          check_field("right_face", got_faces.right_face, out_tdata[2*FIELD_W-1:FIELD_W]);
          check_field("upwind_face", got_faces.upwind_face, out_tdata[3*FIELD_W-1:2*FIELD_W]);
        end
        faces_checked++;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 10);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d face sets still due",
               cycle_count, expected_faces.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic queue_cell(logic [FIELD_W-1:0] s, logic rs, logic flux, logic flr);
    pending_cells.push_back(cell_item_t'{s, rs, flux, flr});
    cells_queued++;
    if (rs) rows_sent++;
  endtask

  task automatic queue_random_row(int len);
    int               style, level, step;
    logic [FIELD_W-1:0] s;
    style = $urandom_range(0, 3);
    level = $urandom;
    step  = 1 << $urandom_range(0, 20);
    for (int k = 0; k < len; k++) begin
      case (style)
        0: s = $urandom;
        1: begin
          level = level + int'($urandom_range(0, 2 * step)) - step;
          s = level;
        end
        2: begin
          case ($urandom_range(0, 3))
            0: s = 32'h7fff_ffff;
            1: s = 32'h8000_0000;
            2: s = '0;
            default: s = $urandom;
          endcase
        end
        default: s = int'($urandom_range(0, 16)) - 8;
      endcase
      queue_cell(s, k == 0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic run_random_phase(int n);
    int len;
    while (n > 0) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 24);
      if (len > n) len = n;
      queue_random_row(len);
      n -= len;
    end
  endtask

  task automatic wait_drained();
    while (cells_taken != cells_queued || expected_faces.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (idx == REG_THETA) theta_q = value[THETA_W-1:0];
    else floor_q = value[FLOOR_W-1:0];
  endtask

  initial begin
    for (int k = 0; k < 3; k++) window_q[k] = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: saturation, short rows, monotone, flat, and rounding ties
    queue_cell(32'h0000_0000, 1'b1, 1'b1, 1'b0);
    queue_cell(32'h7fff_ffff, 1'b0, 1'b1, 1'b0);
    queue_cell(32'h8000_0000, 1'b0, 1'b0, 1'b0);
    queue_cell(32'h7fff_ffff, 1'b0, 1'b1, 1'b0);
    queue_cell(32'h8000_0000, 1'b0, 1'b0, 1'b1);
    queue_cell(32'h0064_0000, 1'b1, 1'b1, 1'b0);
    queue_cell(32'h00c8_0000, 1'b0, 1'b1, 1'b0);
    queue_cell(-32'sh0005_0000, 1'b1, 1'b1, 1'b1);
    queue_cell(-32'sh0004_0000, 1'b0, 1'b1, 1'b1);
    queue_cell(-32'sh0003_0000, 1'b0, 1'b1, 1'b1);
    queue_cell(-32'sh0001_0000, 1'b0, 1'b1, 1'b1);
    queue_cell(32'h0002_0000, 1'b0, 1'b0, 1'b1);
    queue_cell(32'h0002_0000, 1'b0, 1'b1, 1'b0);
    queue_cell(32'h0002_0000, 1'b0, 1'b0, 1'b0);
    queue_cell(32'h0000_0000, 1'b1, 1'b1, 1'b0);
    queue_cell(32'h0000_0001, 1'b0, 1'b0, 1'b0);
    queue_cell(32'h0000_0002, 1'b0, 1'b1, 1'b1);
    queue_cell(32'h0000_0003, 1'b0, 1'b0, 1'b1);
    queue_cell(32'h0000_0004, 1'b0, 1'b1, 1'b0);
    queue_cell(32'hffff_ffff, 1'b0, 1'b0, 1'b0);
    queue_cell(32'h7fff_fffe, 1'b0, 1'b1, 1'b1);
    wait_drained();

    // steepest limiter, floor at or above every sample
    write_reg(REG_THETA, 32'd131072);
    write_reg(REG_FLOOR, 32'h7fff_ffff);
    run_random_phase(RANDOM_ITEMS);
    wait_drained();

    // zero limiter, zero floor
    write_reg(REG_THETA, 32'd0);
    write_reg(REG_FLOOR, 32'd0);
    run_random_phase(RANDOM_ITEMS);
    wait_drained();

    write_reg(REG_THETA, 32'd65536);
    write_reg(REG_FLOOR, $urandom_range(0, 32'h0010_0000));
    run_random_phase(RANDOM_ITEMS);
    wait_drained();

    write_reg(REG_THETA, $urandom_range(0, 131072));
    write_reg(REG_FLOOR, {1'b0, 31'($urandom)});
    run_random_phase(RANDOM_ITEMS);
    wait_drained();

    // closing stretch back at reset values, no idling
    write_reg(REG_THETA, 32'(THETA_RST));
    write_reg(REG_FLOOR, 32'(FLOOR_RST));
    calm = 1'b1;
    run_random_phase(RANDOM_ITEMS);
    wait_drained();

    $display("run covered %0d items in %0d rows and %0d face sets over six register settings",
             cells_taken, rows_sent, faces_checked);
    $display("settings included zero and full theta, zero and top floor; %0d mismatches",
             mismatches);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
